>>> sv/diophantine_solvability_check_unit_assert.svh
`ifndef DIOPHANTINE_SOLVABILITY_CHECK_UNIT_ASSERT_SVH
`define DIOPHANTINE_SOLVABILITY_CHECK_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dsc assertion failed");

// next-cycle implication, checked outside reset
`define DSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dsc assertion failed");

`endif

>>> sv/dsc_pkg.sv
package dsc_pkg;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_GCD   = 4'b0010,
        S_SHIFT = 4'b0100,
        S_MOD   = 4'b1000
    } t_state;

endpackage

>>> sv/diophantine_solvability_check_unit.sv
// channel    | handshake                 | payload
// -----------+---------------------------+----------------------------------------
// command    | start / busy              | i_coeff_a, i_coeff_b, i_constant_c
// result     | o_done (one-cycle strobe) | o_solvable, o_divisor_found
//
// a transaction is taken when start is high and busy is low; busy then stays high
// binary gcd on one shared subtractor: shift, swap or subtract, one per cycle,
// until one operand is zero, then S_SHIFT restores the common power of two
// divisibility of |c| by restoring remainder on the same subtractor, skipped when the gcd is zero
// o_done pulses in the cycle busy falls; the receiver cannot stall the result
// reset (i_rst_n low, synchronous) returns the sequencer to idle with no strobe
module diophantine_solvability_check_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [DATA_WIDTH-1:0] i_coeff_a,
    input  logic [DATA_WIDTH-1:0] i_coeff_b,
    input  logic [DATA_WIDTH-1:0] i_constant_c,
    output logic                  o_done,
    output logic                  o_solvable,
    output logic [DATA_WIDTH-1:0] o_divisor_found
);

    localparam int KW = $clog2(DATA_WIDTH);
    localparam int CW = $clog2(DATA_WIDTH + 1);

    dsc_pkg::t_state r_state, n_state;

    logic [DATA_WIDTH-1:0] r_u, n_u;
    logic [DATA_WIDTH-1:0] r_v, n_v;
    logic [DATA_WIDTH-1:0] r_c, n_c;
    logic [DATA_WIDTH-1:0] r_g, n_g;
    logic [DATA_WIDTH-1:0] r_rem, n_rem;
    logic [KW-1:0]         r_k, n_k;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_done, n_done;
    logic                  r_solvable, n_solvable;

    logic [DATA_WIDTH-1:0] mag_a, mag_b, mag_c;
    logic [DATA_WIDTH:0]   sub_x, sub_y, diff;
    logic                  borrow;
    logic [DATA_WIDTH:0]   rem_sh;
    logic [DATA_WIDTH-1:0] rem_next;

    // magnitudes; the most negative value maps to 2^(DATA_WIDTH-1)
    assign mag_a = i_coeff_a[DATA_WIDTH-1]    ? (~i_coeff_a + 1'b1)    : i_coeff_a;
    assign mag_b = i_coeff_b[DATA_WIDTH-1]    ? (~i_coeff_b + 1'b1)    : i_coeff_b;
    assign mag_c = i_constant_c[DATA_WIDTH-1] ? (~i_constant_c + 1'b1) : i_constant_c;

    // shared subtractor
    assign rem_sh = {r_rem, r_c[DATA_WIDTH-1]};

    always_comb begin
        if (r_state == dsc_pkg::S_MOD) begin
            sub_x = rem_sh;
            sub_y = {1'b0, r_g};
        end else begin
            sub_x = {1'b0, r_u};
            sub_y = {1'b0, r_v};
        end
    end

    assign diff     = sub_x - sub_y;
    assign borrow   = diff[DATA_WIDTH];
    assign rem_next = borrow ? rem_sh[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];

    always_comb begin
        n_state    = r_state;
        n_u        = r_u;
        n_v        = r_v;
        n_c        = r_c;
        n_g        = r_g;
        n_rem      = r_rem;
        n_k        = r_k;
        n_cnt      = r_cnt;
        n_done     = 1'b0;
        n_solvable = r_solvable;
        case (r_state)
            dsc_pkg::S_IDLE: begin
                if (start) begin
                    n_u     = mag_a;
                    n_v     = mag_b;
                    n_c     = mag_c;
                    n_k     = '0;
                    n_state = dsc_pkg::S_GCD;
                end
            end
            dsc_pkg::S_GCD: begin
                if (r_u == '0) begin
                    n_g     = r_v;
                    n_state = dsc_pkg::S_SHIFT;
                end else if (r_v == '0) begin
                    n_g     = r_u;
                    n_state = dsc_pkg::S_SHIFT;
                end else if (!r_u[0] && !r_v[0]) begin
                    n_u = r_u >> 1;
                    n_v = r_v >> 1;
                    n_k = r_k + 1'b1;
                end else if (!r_u[0]) begin
                    n_u = r_u >> 1;
                end else if (!r_v[0]) begin
                    n_v = r_v >> 1;
                end else if (borrow) begin
                    n_u = r_v;
                    n_v = r_u;
                end else begin
                    n_u = diff[DATA_WIDTH-1:0];
                end
            end
            dsc_pkg::S_SHIFT: begin
                n_g = r_g << r_k;
                if (r_g == '0) begin
                    // both coefficients zero
                    n_solvable = (r_c == '0);
                    n_done     = 1'b1;
                    n_state    = dsc_pkg::S_IDLE;
                end else begin
                    n_rem   = '0;
                    n_cnt   = CW'(DATA_WIDTH);
                    n_state = dsc_pkg::S_MOD;
                end
            end
            dsc_pkg::S_MOD: begin
                n_rem = rem_next;
                n_c   = r_c << 1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    n_solvable = (rem_next == '0);
                    n_done     = 1'b1;
                    n_state    = dsc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dsc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dsc_pkg::S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u        <= n_u;
        r_v        <= n_v;
        r_c        <= n_c;
        r_g        <= n_g;
        r_rem      <= n_rem;
        r_k        <= n_k;
        r_cnt      <= n_cnt;
        r_solvable <= n_solvable;
    end

    assign busy            = (r_state != dsc_pkg::S_IDLE);
    assign o_done          = r_done;
    assign o_solvable      = r_solvable;
    assign o_divisor_found = r_g;

`include "diophantine_solvability_check_unit_assert.svh"

    `DSC_ASSERT_NEXT(a_start_sets_busy, i_clk, i_rst_n, start && !busy, busy)
    `DSC_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)
    `DSC_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, o_done, !busy)
    `DSC_ASSERT_NOW(a_mod_nonzero_divisor, i_clk, i_rst_n,
        r_state == dsc_pkg::S_MOD, r_g != '0)

endmodule

>>> tb/sv/diophantine_solvability_check_unit_tb.sv
`timescale 1ns / 100ps

module diophantine_solvability_check_unit_tb;

    localparam int DW            = 32;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS  = 1630;

    typedef struct packed {
        logic          solvable;
        logic [DW-1:0] divisor;
    } t_verdict;

    logic          i_clk        = 1'b0;
    logic          i_rst_n      = 1'b0;
    logic          start        = 1'b0;
    logic [DW-1:0] i_coeff_a    = '0;
    logic [DW-1:0] i_coeff_b    = '0;
    logic [DW-1:0] i_constant_c = '0;
    logic          busy;
    logic          o_done;
    logic          o_solvable;
    logic [DW-1:0] o_divisor_found;

    t_verdict    expected_verdicts[$];
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles    = 0;
    int unsigned max_gap        = 6;

    diophantine_solvability_check_unit #(
        .DATA_WIDTH(DW)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_coeff_a      (i_coeff_a),
        .i_coeff_b      (i_coeff_b),
        .i_constant_c   (i_constant_c),
        .o_done         (o_done),
        .o_solvable     (o_solvable),
        .o_divisor_found(o_divisor_found)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [DW-1:0] magnitude(input logic [DW-1:0] v);
        logic [DW-1:0] m;
        m = v[DW-1] ? (~v + 1'b1) : v;
        return m;
    endfunction

    function automatic t_verdict solve_equation(input logic [DW-1:0] a,
                                                input logic [DW-1:0] b,
                                                input logic [DW-1:0] c);
        logic [DW-1:0] x;
        logic [DW-1:0] y;
        logic [DW-1:0] r;
        logic [DW-1:0] mc;
        t_verdict      v;
        x  = magnitude(a);
        y  = magnitude(b);
        mc = magnitude(c);
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        v.divisor  = x;
        v.solvable = (x == 0) ? (mc == 0) : ((mc % x) == 0);
        return v;
    endfunction

    function automatic logic [DW-1:0] corner_value();
        logic [DW-1:0] v;
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = 32'd1;
            2: v = '1;
            3: v = 32'h7fff_ffff;
            4: v = 32'h8000_0000;
            5: v = 32'h8000_0001;
            6: v = 32'd2;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [DW-1:0] signed_multiple(input logic [DW-1:0] g,
                                                      input int unsigned limit);
        logic [DW-1:0] v;
        v = g * $urandom_range(0, limit);
        if ($urandom_range(0, 1) == 1) begin
            v = ~v + 1'b1;
        end
        return v;
    endfunction

    // check each result, then record the transaction taken at this edge
    always @(posedge i_clk) begin : check_results
        t_verdict want;
        if (i_rst_n) begin
            if (o_done === 1'b1) begin
                if (expected_verdicts.size() == 0) begin
                    $error("result strobe with no transaction outstanding");
                    mismatch_count++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (o_solvable !== want.solvable) begin
                        $error("solvable: expected %0d, actual %0d",
                               want.solvable, o_solvable);
                        mismatch_count++;
                    end
                    if (o_divisor_found !== want.divisor) begin
                        $error("divisor_found: expected %0d, actual %0d",
                               want.divisor, o_divisor_found);
                        mismatch_count++;
                    end
                end
            end
            if (start && busy === 1'b0) begin
                expected_verdicts.push_back(
                    solve_equation(i_coeff_a, i_coeff_b, i_constant_c));
            end
            if ((start && busy === 1'b0) || o_done === 1'b1) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("Mismatches found");
        $finish;
    end

    task automatic send_equation(input logic [DW-1:0] a,
                                 input logic [DW-1:0] b,
                                 input logic [DW-1:0] c);
        int unsigned gap;
        gap = $urandom_range(0, max_gap);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_coeff_a    <= a;
        i_coeff_b    <= b;
        i_constant_c <= c;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        do @(posedge i_clk); while (expected_verdicts.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_extremes();
        send_equation(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_equation(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_equation(32'h8000_0000, 32'h8000_0000, 32'h4000_0000);
        send_equation(32'h8000_0000, 32'h7fff_ffff, 32'd5);
        send_equation('1, '1, '1);
        send_equation(32'd1, 32'd1, 32'h8000_0000);
    endtask

    task automatic test_signs();
        send_equation(32'd6, 32'd10, 32'd8);
        send_equation(-32'sd6, 32'd10, 32'd8);
        send_equation(32'd6, -32'sd10, -32'sd8);
        send_equation(-32'sd6, -32'sd10, 32'd7);
        send_equation(32'd12, 32'd18, -32'sd6);
    endtask

    task automatic test_zero_coefficients();
        send_equation('0, '0, '0);
        send_equation('0, '0, 32'd5);
        send_equation('0, '0, 32'h8000_0000);
        send_equation('0, -32'sd12, 32'd36);
        send_equation(-32'sd15, '0, 32'd10);
        send_equation('0, 32'h8000_0000, '0);
    endtask

    task automatic test_euclid_depth();
        send_equation(32'd17, 32'd13, 32'd1);
        send_equation(32'd1024, 32'd768, 32'd256);
        send_equation(32'd1836311903, 32'd1134903170, 32'd1);
    endtask

    task automatic test_random(input int unsigned count);
        logic [DW-1:0] a;
        logic [DW-1:0] b;
        logic [DW-1:0] c;
        logic [DW-1:0] g;
        for (int unsigned n = 0; n < count; n++) begin
            if (n % 150 == 0) begin
                max_gap = ($urandom_range(0, 3) == 0) ? 0 : 6;
            end
            if (n == count / 2) begin
                wait_for_results();
            end
            case ($urandom_range(0, 4))
                0: begin
                    a = $urandom;
                    b = $urandom;
                    c = $urandom;
                end
                1: begin
                    g = $urandom_range(1, 4096);
                    a = signed_multiple(g, 65535);
                    b = signed_multiple(g, 65535);
                    c = signed_multiple(g, 65535) + (($urandom_range(0, 1) == 1) ?
                        32'd0 : $urandom_range(1, 3));
                end
                2: begin
                    a = $urandom << $urandom_range(0, 31);
                    b = $urandom << $urandom_range(0, 31);
                    c = $urandom << $urandom_range(0, 31);
                end
                3: begin
                    a = corner_value();
                    b = corner_value();
                    c = corner_value();
                end
                default: begin
                    g = $urandom_range(1, 255) << $urandom_range(0, 20);
                    a = signed_multiple(g, 255);
                    b = signed_multiple(g, 255);
                    c = ($urandom_range(0, 1) == 1) ? signed_multiple(g, 1000) : $urandom;
                end
            endcase
            send_equation(a, b, c);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_extremes();
        test_signs();
        test_zero_coefficients();
        test_euclid_depth();
        test_random(RANDOM_ITEMS);
        wait_for_results();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
